>>> design/binary_image_convex_hull_defines.svh
// Assertion macros for the convex hull block.
// Included by the top level; uses its clk and rst_n.
`ifndef BINARY_IMAGE_CONVEX_HULL_DEFINES_SVH
`define BINARY_IMAGE_CONVEX_HULL_DEFINES_SVH

// Condition that holds at every edge out of reset.
`define BICH_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define BICH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bich_pkg.sv
// Shared types, register codes and geometry helpers for the convex hull block.
// No dependencies.
`default_nettype none

package bich_pkg;

  localparam int ROW_W     = 64;
  localparam int COORD_W   = 6;
  localparam int PT_W      = 12;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 7'd64;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 7'd64;
  localparam logic [CFG_W-1:0] MAX_WIDTH    = 7'd64;
  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 7'd64;

  typedef logic [PT_W-1:0] point_t;      // {y, x}
  typedef logic signed [14:0] cross_t;

  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0]   hull_row_bits;
    logic [COORD_W-1:0] row_index;
    logic               last_out;
  } out_word_t;

  // Cross product (b - a) x (c - a); positive means a left turn.
  function automatic cross_t turn(point_t a, point_t b, point_t c);
    logic signed [6:0]  bx, by, cx, cy;
    logic signed [13:0] p0, p1;
    bx = $signed({1'b0, b[5:0]})  - $signed({1'b0, a[5:0]});
    by = $signed({1'b0, b[11:6]}) - $signed({1'b0, a[11:6]});
    cx = $signed({1'b0, c[5:0]})  - $signed({1'b0, a[5:0]});
    cy = $signed({1'b0, c[11:6]}) - $signed({1'b0, a[11:6]});
    p0 = bx * cy;
    p1 = by * cx;
    return cross_t'({p0[13], p0}) - cross_t'({p1[13], p1});
  endfunction

  function automatic logic [6:0] manhattan(point_t p, point_t anc);
    logic signed [6:0] dx, dy;
    logic [6:0]        ax, ay;
    dx = $signed({1'b0, p[5:0]})  - $signed({1'b0, anc[5:0]});
    dy = $signed({1'b0, p[11:6]}) - $signed({1'b0, anc[11:6]});
    ax = dx[6] ? 7'(-dx) : 7'(dx);
    ay = dy[6] ? 7'(-dy) : 7'(dy);
    return ax + ay;
  endfunction

  // a strictly precedes b in angular order around anc; ties go nearest first
  function automatic logic precedes(point_t a, point_t b, point_t anc);
    cross_t c;
    c = turn(anc, a, b);
    if (c != '0) return c > 0;
    return manhattan(a, anc) < manhattan(b, anc);
  endfunction

endpackage

`default_nettype wire

>>> design/bich_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bich_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/binary_image_convex_hull.sv
// Convex hull vertex mask of a binary image, Graham scan over stored points.
// Depends on bich_pkg, bich_ram and binary_image_convex_hull_defines.svh.
//
// Usage:
//   Input: one image row per word on in_data, taken when start is high and
//   busy is low. Rows arrive top first; in_data.last_row ends the frame.
//   Config: cfg_index/cfg_data written when cfg_valid and cfg_ready are high
//   (cfg_ready is always high). Write only while busy is low.
//   Output: after a last row, one word per image row on out_data, each
//   marked by a single-cycle out_strobe; the receiver cannot stall.
// Flow:
//   A row is registered, then each white pixel kept is stored in turn (one
//   point store write per cycle). On the last row, with n points and m = n-1:
//     sort  : merge passes over the m points besides the anchor, ping-ponging
//             between the point RAM and a scratch RAM, one read port each;
//     scan  : a load and a test per point, plus stack RAM reads on pops;
//     mark  : per hull vertex a stack read, a mask read and a mask write;
//     emit  : a mask read and an emit per mask row.
//   busy stays high throughout.
// Reset: clears counters, registers to 64, mask valid bits. No clearing pass;
//   the mask RAM is qualified by per-row valid bits that clear every frame.
`default_nettype none

`include "binary_image_convex_hull_defines.svh"

module binary_image_convex_hull #(
  parameter int MAX_POINTS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bich_pkg::in_word_t          in_data,
  output logic                             out_strobe,
  output bich_pkg::out_word_t              out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [bich_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bich_pkg::CFG_W-1:0]  cfg_data
);

  import bich_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  // sequencer states
  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_COL     = 5'd1;
  localparam logic [4:0] ST_SRT     = 5'd2;
  localparam logic [4:0] ST_SEG     = 5'd3;
  localparam logic [4:0] ST_SEGA    = 5'd4;
  localparam logic [4:0] ST_SEGB    = 5'd5;
  localparam logic [4:0] ST_MRG     = 5'd6;
  localparam logic [4:0] ST_MLD     = 5'd7;
  localparam logic [4:0] ST_SC_INIT = 5'd8;
  localparam logic [4:0] ST_SC_LD   = 5'd9;
  localparam logic [4:0] ST_SC_TST  = 5'd10;
  localparam logic [4:0] ST_SC_POP  = 5'd11;
  localparam logic [4:0] ST_MK_RD   = 5'd12;
  localparam logic [4:0] ST_MK_MR   = 5'd13;
  localparam logic [4:0] ST_MK_WR   = 5'd14;
  localparam logic [4:0] ST_OUT_RD  = 5'd15;
  localparam logic [4:0] ST_OUT_EM  = 5'd16;

  // control state
  logic [4:0]       state_r, state_nxt;
  logic [CFG_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [5:0]       row_ctr_r, row_ctr_nxt;
  logic             passed_r, passed_nxt;
  logic [63:0]      vld_r, vld_nxt;
  logic             strobe_r, strobe_nxt;
  point_t           anchor_r, anchor_nxt;
  logic [CW-1:0]    depth_r, depth_nxt;
  logic             src_r, src_nxt;      // 0: point RAM holds current run data

  // datapath registers
  logic [63:0]      bits_r, bits_nxt;
  logic             last_r, last_nxt;
  logic [5:0]       cur_y_r, cur_y_nxt;
  logic [CW-1:0]    m_r, m_nxt;
  logic [CW-1:0]    w_r, w_nxt, lo_r, lo_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CW-1:0]    mid_r, mid_nxt, hi_r, hi_nxt;
  point_t           ha_r, ha_nxt, hb_r, hb_nxt;
  logic             take_b_r, take_b_nxt;
  point_t           t1_r, t1_nxt, t2_r, t2_nxt, p_r, p_nxt, pt_r, pt_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [5:0]       y_r, y_nxt;
  out_word_t        out_r, out_nxt;

  // memory ports
  logic          col_we, dst_we;
  logic [AW-1:0] col_waddr, dst_waddr, src_raddr;
  point_t        col_wdata, dst_wdata;
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr;
  point_t        a_wdata, a_rdata, b_rdata, src_rdata;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  point_t        s_wdata, s_rdata;
  logic          k_we;
  logic [5:0]    k_waddr, k_raddr;
  logic [63:0]   k_wdata, k_rdata;

  // helpers
  logic [CFG_W-1:0] eff_w, eff_h;
  logic [63:0]      col_mask;
  logic             row_ok;
  logic [5:0]       low_x;
  logic             full;
  logic [CW:0]      sum_w, sum_2w, w2;
  logic             a_ok, b_ok, tb;
  cross_t           tst_turn;
  logic [63:0]      mask_old;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  always_comb begin
    eff_w = (width_r == '0) ? 7'd1 : ((width_r > MAX_WIDTH) ? MAX_WIDTH : width_r);
    eff_h = (height_r == '0) ? 7'd1 : ((height_r > MAX_HEIGHT) ? MAX_HEIGHT : height_r);
    for (int x = 0; x < 64; x++) begin
      col_mask[x] = (7'(x) < eff_w);
    end
    row_ok = !passed_r && ({1'b0, row_ctr_r} < eff_h);
  end

  // lowest white pixel of the pending row
  always_comb begin
    low_x = '0;
    for (int x = 63; x >= 0; x--) begin
      if (bits_r[x]) begin
        low_x = 6'(x);
      end
    end
  end

  assign full     = (count_r == CW'(MAX_POINTS));
  assign sum_w    = {1'b0, lo_r} + {1'b0, w_r};
  assign sum_2w   = {1'b0, lo_r} + {w_r, 1'b0};
  assign w2       = {w_r, 1'b0};
  assign a_ok     = (i_r < mid_r);
  assign b_ok     = (j_r < hi_r);
  assign tb       = b_ok && (!a_ok || precedes(hb_r, ha_r, anchor_r));
  assign tst_turn = turn(t2_r, t1_r, p_r);
  assign mask_old = vld_r[pt_r[11:6]] ? k_rdata : '0;

  always_comb begin
    state_nxt  = state_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    count_nxt  = count_r;
    row_ctr_nxt = row_ctr_r;
    passed_nxt = passed_r;
    vld_nxt    = vld_r;
    strobe_nxt = 1'b0;
    anchor_nxt = anchor_r;
    depth_nxt  = depth_r;
    src_nxt    = src_r;
    bits_nxt   = bits_r;
    last_nxt   = last_r;
    cur_y_nxt  = cur_y_r;
    m_nxt      = m_r;
    w_nxt      = w_r;
    lo_nxt     = lo_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    mid_nxt    = mid_r;
    hi_nxt     = hi_r;
    ha_nxt     = ha_r;
    hb_nxt     = hb_r;
    take_b_nxt = take_b_r;
    t1_nxt     = t1_r;
    t2_nxt     = t2_r;
    p_nxt      = p_r;
    pt_nxt     = pt_r;
    idx_nxt    = idx_r;
    y_nxt      = y_r;
    out_nxt    = out_r;
    col_we     = 1'b0;
    col_waddr  = AW'(count_r - 1'b1);
    col_wdata  = {cur_y_r, low_x};
    dst_we     = 1'b0;
    dst_waddr  = k_r[AW-1:0];
    dst_wdata  = tb ? hb_r : ha_r;
    src_raddr  = '0;
    s_we       = 1'b0;
    s_waddr    = depth_r[AW-1:0];
    s_wdata    = p_r;
    s_raddr    = '0;
    k_we       = 1'b0;
    k_waddr    = pt_r[11:6];
    k_wdata    = mask_old | (64'd1 << pt_r[5:0]);
    k_raddr    = y_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        REG_IMAGE_HEIGHT: height_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          bits_nxt  = row_ok ? (in_data.row_bits & col_mask) : '0;
          last_nxt  = in_data.last_row;
          cur_y_nxt = row_ctr_r;
          if (row_ctr_r == 6'd63) begin
            passed_nxt = 1'b1;
          end else begin
            row_ctr_nxt = row_ctr_r + 6'd1;
          end
          state_nxt = ST_COL;
        end
      end
      ST_COL: begin
        if (bits_r == '0 || full) begin
          state_nxt = last_r ? ST_SRT : ST_IDLE;
        end else begin
          // raster order: the first point is lowest y, then lowest x
          if (count_r == '0) begin
            anchor_nxt = {cur_y_r, low_x};
          end else begin
            col_we = 1'b1;
          end
          count_nxt = count_r + 1'b1;
          bits_nxt  = bits_r & (bits_r - 64'd1);
        end
      end
      ST_SRT: begin
        m_nxt  = (count_r == '0) ? '0 : count_r - 1'b1;
        w_nxt  = CW'(1);
        lo_nxt = '0;
        src_nxt = 1'b0;
        state_nxt = (count_r <= CW'(2)) ? ST_SC_INIT : ST_SEG;
      end
      ST_SEG: begin
        mid_nxt = (sum_w >= {1'b0, m_r}) ? m_r : sum_w[CW-1:0];
        hi_nxt  = (sum_2w >= {1'b0, m_r}) ? m_r : sum_2w[CW-1:0];
        i_nxt   = lo_r;
        j_nxt   = (sum_w >= {1'b0, m_r}) ? m_r : sum_w[CW-1:0];
        k_nxt   = lo_r;
        src_raddr = lo_r[AW-1:0];
        state_nxt = ST_SEGA;
      end
      ST_SEGA: begin
        ha_nxt    = src_rdata;
        src_raddr = j_r[AW-1:0];
        state_nxt = ST_SEGB;
      end
      ST_SEGB: begin
        hb_nxt    = src_rdata;
        state_nxt = ST_MRG;
      end
      ST_MRG: begin
        if (!a_ok && !b_ok) begin
          if (sum_2w >= {1'b0, m_r}) begin
            // pass done
            src_nxt = !src_r;
            lo_nxt  = '0;
            w_nxt   = w2[CW-1:0];
            state_nxt = (w2 >= {1'b0, m_r}) ? ST_SC_INIT : ST_SEG;
          end else begin
            lo_nxt    = sum_2w[CW-1:0];
            state_nxt = ST_SEG;
          end
        end else begin
          dst_we     = 1'b1;
          k_nxt      = k_r + 1'b1;
          take_b_nxt = tb;
          if (tb) begin
            j_nxt     = j_r + 1'b1;
            src_raddr = AW'(j_r + 1'b1);
          end else begin
            i_nxt     = i_r + 1'b1;
            src_raddr = AW'(i_r + 1'b1);
          end
          state_nxt = ST_MLD;
        end
      end
      ST_MLD: begin
        if (take_b_r) begin
          hb_nxt = src_rdata;
        end else begin
          ha_nxt = src_rdata;
        end
        state_nxt = ST_MRG;
      end
      ST_SC_INIT: begin
        depth_nxt = '0;
        idx_nxt   = '0;
        y_nxt     = '0;
        if (count_r == '0) begin
          state_nxt = ST_MK_RD;
        end else begin
          s_we      = 1'b1;
          s_waddr   = '0;
          s_wdata   = anchor_r;
          t1_nxt    = anchor_r;
          depth_nxt = CW'(1);
          src_raddr = '0;
          state_nxt = (m_r == '0) ? ST_MK_RD : ST_SC_LD;
        end
      end
      ST_SC_LD: begin
        p_nxt     = src_rdata;
        state_nxt = ST_SC_TST;
      end
      ST_SC_TST: begin
        if (depth_r >= CW'(2) && tst_turn <= 0) begin
          // collinear or right turn: pop
          depth_nxt = depth_r - 1'b1;
          t1_nxt    = t2_r;
          if (depth_r >= CW'(3)) begin
            s_raddr   = AW'(depth_r - CW'(3));
            state_nxt = ST_SC_POP;
          end
        end else begin
          s_we      = 1'b1;
          t2_nxt    = t1_r;
          t1_nxt    = p_r;
          depth_nxt = depth_r + 1'b1;
          idx_nxt   = idx_r + 1'b1;
          if ((idx_r + 1'b1) < m_r) begin
            src_raddr = AW'(idx_r + 1'b1);
            state_nxt = ST_SC_LD;
          end else begin
            state_nxt = ST_MK_RD;
          end
        end
      end
      ST_SC_POP: begin
        t2_nxt    = s_rdata;
        state_nxt = ST_SC_TST;
      end
      ST_MK_RD: begin
        if (idx_r >= depth_r || depth_r == '0) begin
          state_nxt = ST_OUT_RD;
        end else begin
          s_raddr   = idx_r[AW-1:0];
          state_nxt = ST_MK_MR;
        end
      end
      ST_MK_MR: begin
        pt_nxt    = s_rdata;
        k_raddr   = s_rdata[11:6];
        state_nxt = ST_MK_WR;
      end
      ST_MK_WR: begin
        k_we = 1'b1;
        vld_nxt[pt_r[11:6]] = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_MK_RD;
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT_EM;
      end
      ST_OUT_EM: begin
        strobe_nxt = 1'b1;
        out_nxt.hull_row_bits = vld_r[y_r] ? k_rdata : '0;
        out_nxt.row_index     = y_r;
        out_nxt.last_out      = ({1'b0, y_r} + 7'd1 == eff_h);
        if ({1'b0, y_r} + 7'd1 == eff_h) begin
          // frame done
          count_nxt   = '0;
          depth_nxt   = '0;
          row_ctr_nxt = '0;
          passed_nxt  = 1'b0;
          vld_nxt     = '0;
          state_nxt   = ST_IDLE;
        end else begin
          y_nxt     = y_r + 6'd1;
          state_nxt = ST_OUT_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // at mark start idx_r is reused as the mark pointer
    if (state_r == ST_SC_TST && state_nxt == ST_MK_RD) begin
      idx_nxt = '0;
    end
    if (state_r == ST_SC_INIT && state_nxt == ST_MK_RD) begin
      idx_nxt = '0;
    end
  end

  // point RAM / scratch RAM steering
  assign a_we      = col_we | (dst_we & src_r);
  assign a_waddr   = col_we ? col_waddr : dst_waddr;
  assign a_wdata   = col_we ? col_wdata : dst_wdata;
  assign b_we      = dst_we & !src_r;
  assign src_rdata = src_r ? b_rdata : a_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      count_r   <= '0;
      row_ctr_r <= '0;
      passed_r  <= 1'b0;
      vld_r     <= '0;
      strobe_r  <= 1'b0;
      anchor_r  <= '0;
      depth_r   <= '0;
      src_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      count_r   <= count_nxt;
      row_ctr_r <= row_ctr_nxt;
      passed_r  <= passed_nxt;
      vld_r     <= vld_nxt;
      strobe_r  <= strobe_nxt;
      anchor_r  <= anchor_nxt;
      depth_r   <= depth_nxt;
      src_r     <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r   <= bits_nxt;
    last_r   <= last_nxt;
    cur_y_r  <= cur_y_nxt;
    m_r      <= m_nxt;
    w_r      <= w_nxt;
    lo_r     <= lo_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    mid_r    <= mid_nxt;
    hi_r     <= hi_nxt;
    ha_r     <= ha_nxt;
    hb_r     <= hb_nxt;
    take_b_r <= take_b_nxt;
    t1_r     <= t1_nxt;
    t2_r     <= t2_nxt;
    p_r      <= p_nxt;
    pt_r     <= pt_nxt;
    idx_r    <= idx_nxt;
    y_r      <= y_nxt;
    out_r    <= out_nxt;
  end

  bich_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(src_raddr), .rdata(a_rdata)
  );

  bich_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_scratch_ram (
    .clk(clk), .we(b_we), .waddr(dst_waddr), .wdata(dst_wdata),
    .raddr(src_raddr), .rdata(b_rdata)
  );

  bich_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_stack_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  bich_ram #(.WIDTH(ROW_W), .DEPTH(64)) u_mask_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  // checks
  `BICH_ASSERT_NEXT(a_strobe_from_emit, state_r == ST_OUT_EM, out_strobe, "missing mask word")
  `BICH_ASSERT_ALWAYS(a_stack_bound, depth_r <= count_r, "hull stack deeper than point count")
  `BICH_ASSERT_NEXT(a_frame_clear, state_r == ST_OUT_EM && state_nxt == ST_IDLE, vld_r == '0 && count_r == '0, "frame state not cleared")

endmodule

`default_nettype wire
